@@ sv/ilru_pkg.sv @@
// Shared constants and types for the indexed LRU list.
package ilru_pkg;

	// Width of the entry index field on the stream ports.
	localparam int ENTRY_W = 10;
	// Highest number of pool positions that the entry index field can reach.
	localparam int ENTRY_SPAN = 1 << ENTRY_W;
	localparam int OP_W = 3;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ADD_HEAD  = 3'd0;
	localparam logic [OP_W-1:0] OP_ADD_TAIL  = 3'd1;
	localparam logic [OP_W-1:0] OP_MOVE_HEAD = 3'd2;
	localparam logic [OP_W-1:0] OP_MOVE_TAIL = 3'd3;
	localparam logic [OP_W-1:0] OP_REMOVE    = 3'd4;

	// Result of one operation, handed from the controller to the output stage.
	typedef struct packed {
		logic               done_res;
		logic               list_empty;
		logic [ENTRY_W-1:0] head_index;
		logic [ENTRY_W-1:0] tail_index;
	} res_t;

endpackage

@@ sv/ilru_link_ram.sv @@
// Single-port synchronous link memory with registered read data.
module ilru_link_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] addr,
	input  logic [AW-1:0] wdata,
	output logic [AW-1:0] rdata
);

	logic [AW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

@@ sv/ilru_ctrl.sv @@
// Sequencer for the LRU list: clearing sweep, link read, guard check and link writes.
module ilru_ctrl
	import ilru_pkg::*;
#(
	parameter int POOL_ENTRIES = 1024,
	parameter int DEPTH        = 1024,
	parameter int LW           = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [OP_W-1:0]    in_op,
	input  logic [ENTRY_W-1:0] in_entry,
	output logic               res_valid,
	input  logic               res_ready,
	output res_t               res,
	output logic               prev_we,
	output logic [LW-1:0]      prev_addr,
	output logic [LW-1:0]      prev_wdata,
	input  logic [LW-1:0]      prev_rdata,
	output logic               next_we,
	output logic [LW-1:0]      next_addr,
	output logic [LW-1:0]      next_wdata,
	input  logic [LW-1:0]      next_rdata
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_WRITE,
		ST_RESP
	} state_t;

	state_t          state_q;
	logic [LW-1:0]   clr_q;
	logic [OP_W-1:0] op_q;
	logic [LW-1:0]   e_q;
	logic            in_range_q;
	logic [LW-1:0]   head_q;
	logic [LW-1:0]   tail_q;
	logic [1:0]      step_q;
	logic [1:0]      last_q;
	logic [LW-1:0]   pa_q [4];
	logic [LW-1:0]   pd_q [4];
	logic [LW-1:0]   na_q [4];
	logic [LW-1:0]   nd_q [4];
	res_t            res_q;

	logic [LW-1:0]   pa_d [4];
	logic [LW-1:0]   pd_d [4];
	logic [LW-1:0]   na_d [4];
	logic [LW-1:0]   nd_d [4];
	logic [1:0]      last_d;
	logic            ok;
	logic            e_nz;
	logic            is_self;
	logic            move_ok;
	logic [LW-1:0]   p;
	logic [LW-1:0]   n;
	logic [LW-1:0]   head_d;
	logic [LW-1:0]   tail_d;
	logic            in_range;
	res_t            res_now;

	assign in_ready = (state_q == ST_IDLE);
	assign in_range = (32'(in_entry) < 32'(POOL_ENTRIES));
	assign p        = prev_rdata;
	assign n        = next_rdata;
	assign e_nz     = (e_q != '0);
	assign is_self  = (n == e_q) && (p == e_q);
	assign move_ok  = e_nz && (n != e_q) && (p != e_q) && (n != p);

	// Guard check and write plan; each store gets its writes in the order of the
	// link updates, so aliased addresses end with the last written value.
	always_comb begin
		ok     = 1'b0;
		last_d = 2'd1;
		for (int i = 0; i < 4; i++) begin
			pa_d[i] = '0;
			pd_d[i] = '0;
			na_d[i] = '0;
			nd_d[i] = '0;
		end
		unique case (op_q)
			OP_ADD_HEAD: begin
				ok = e_nz && (p != '0) && is_self;
				pa_d[0] = head_q; pd_d[0] = e_q;
				pa_d[1] = e_q;    pd_d[1] = '0;
				na_d[0] = e_q;    nd_d[0] = head_q;
				na_d[1] = '0;     nd_d[1] = e_q;
			end
			OP_ADD_TAIL: begin
				ok = e_nz && (n != '0) && is_self;
				pa_d[0] = '0;     pd_d[0] = e_q;
				pa_d[1] = e_q;    pd_d[1] = tail_q;
				na_d[0] = e_q;    nd_d[0] = '0;
				na_d[1] = tail_q; nd_d[1] = e_q;
			end
			OP_MOVE_HEAD: begin
				ok = move_ok && (p != '0);
				last_d = 2'd3;
				pa_d[0] = n;      pd_d[0] = p;
				pa_d[1] = e_q;    pd_d[1] = e_q;
				pa_d[2] = head_q; pd_d[2] = e_q;
				pa_d[3] = e_q;    pd_d[3] = '0;
				na_d[0] = p;      nd_d[0] = n;
				na_d[1] = e_q;    nd_d[1] = e_q;
				na_d[2] = e_q;    nd_d[2] = head_q;
				na_d[3] = '0;     nd_d[3] = e_q;
			end
			OP_MOVE_TAIL: begin
				ok = move_ok && (n != '0);
				last_d = 2'd3;
				pa_d[0] = n;      pd_d[0] = p;
				pa_d[1] = e_q;    pd_d[1] = e_q;
				pa_d[2] = '0;     pd_d[2] = e_q;
				pa_d[3] = e_q;    pd_d[3] = tail_q;
				na_d[0] = p;      nd_d[0] = n;
				na_d[1] = e_q;    nd_d[1] = e_q;
				na_d[2] = e_q;    nd_d[2] = '0;
				na_d[3] = tail_q; nd_d[3] = e_q;
			end
			OP_REMOVE: begin
				ok = e_nz && (n != e_q) && (p != e_q);
				pa_d[0] = n;      pd_d[0] = p;
				pa_d[1] = e_q;    pd_d[1] = e_q;
				na_d[0] = p;      nd_d[0] = n;
				na_d[1] = e_q;    nd_d[1] = e_q;
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		ok = ok && in_range_q;
	end

	// Memory port selection.
	always_comb begin
		prev_we    = 1'b0;
		next_we    = 1'b0;
		prev_addr  = in_entry[LW-1:0];
		next_addr  = in_entry[LW-1:0];
		prev_wdata = pd_q[step_q];
		next_wdata = nd_q[step_q];
		unique case (state_q)
			ST_CLEAR: begin
				prev_we    = 1'b1;
				next_we    = 1'b1;
				prev_addr  = clr_q;
				next_addr  = clr_q;
				prev_wdata = clr_q;
				next_wdata = clr_q;
			end
			ST_WRITE: begin
				prev_we   = 1'b1;
				next_we   = 1'b1;
				prev_addr = pa_q[step_q];
				next_addr = na_q[step_q];
			end
			default: begin
				prev_we = 1'b0;
			end
		endcase
	end

	// Root links after this cycle's writes.
	assign head_d = (next_we && (next_addr == '0)) ? next_wdata : head_q;
	assign tail_d = (prev_we && (prev_addr == '0)) ? prev_wdata : tail_q;

	assign res_now.done_res   = (state_q == ST_WRITE);
	assign res_now.list_empty = (head_d == '0);
	assign res_now.head_index = ENTRY_W'(head_d);
	assign res_now.tail_index = ENTRY_W'(tail_d);

	assign res_valid = (state_q == ST_RESP) || ((state_q == ST_EVAL) && !ok) ||
		((state_q == ST_WRITE) && (step_q == last_q));
	assign res = (state_q == ST_RESP) ? res_q : res_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			head_q     <= '0;
			tail_q     <= '0;
			step_q     <= '0;
			last_q     <= '0;
			op_q       <= '0;
			e_q        <= '0;
			in_range_q <= 1'b0;
		end else begin
			head_q <= head_d;
			tail_q <= tail_d;
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LW'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						op_q       <= in_op;
						e_q        <= in_entry[LW-1:0];
						in_range_q <= in_range;
						state_q    <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (ok) begin
						pa_q    <= pa_d;
						pd_q    <= pd_d;
						na_q    <= na_d;
						nd_q    <= nd_d;
						last_q  <= last_d;
						step_q  <= '0;
						state_q <= ST_WRITE;
					end else if (res_ready) begin
						state_q <= ST_IDLE;
					end else begin
						res_q   <= res_now;
						state_q <= ST_RESP;
					end
				end
				ST_WRITE: begin
					if (step_q == last_q) begin
						if (res_ready) begin
							state_q <= ST_IDLE;
						end else begin
							res_q   <= res_now;
							state_q <= ST_RESP;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_RESP: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_accept_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EVAL))
		else $error("accepted beat did not start evaluation");

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_EVAL || state_q == ST_RESP) |-> !(prev_we || next_we))
		else $error("link write outside clear or write phase");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRITE) |-> (step_q <= last_q))
		else $error("write step ran past its plan");

	a_handoff_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> (state_q == ST_IDLE))
		else $error("result handed off but sequencer not idle");

	a_root_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((head_q == '0) == (tail_q == '0)))
		else $error("root head and tail links disagree on emptiness");
`endif

endmodule

@@ sv/indexed_lru_list.sv @@
// Top level of the indexed LRU list: link memories, sequencer and output register.
//
// This block keeps an LRU order over a pool of entries as a circular doubly
// linked list, with entry 0 as the root: the root's next link is the head (most
// recently used) and its previous link is the tail (the eviction candidate).
// Each input beat asks to add an entry at the head or tail, move a listed entry
// to the head or tail, or remove it, and yields exactly one output beat with the
// done flag, the empty flag, the head and the tail. The links live in two
// single-ported memories (previous and next), read together in the cycle after a
// beat is accepted and then rewritten one link per memory per cycle. An add or a
// remove therefore rewrites two links in each memory, a move four, and an item
// whose guard fails, or whose operation code or entry is out of range, none,
// before the next beat can be accepted; its result is offered to the output
// register in the last write step, or in the guard check when nothing is written.
// One item is in work at a time. The result is parked in an output register, so
// the next beat is accepted while a result still waits.
// After reset a clearing pass makes every entry link to itself, one entry per
// cycle over min(POOL_ENTRIES, 1024) entries, and no beat is accepted until it
// ends. Entries at or beyond POOL_ENTRIES are reported as not done.
module indexed_lru_list
	import ilru_pkg::*;
#(
	parameter int POOL_ENTRIES = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // op [2:0], entry_index [12:3], zero [15:13]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata    // done_res [0], list_empty [1], head_index [11:2],
	                               // tail_index [21:12], zero [23:22]
);

	// Only positions reachable by the entry index field are stored.
	localparam int DEPTH = (POOL_ENTRIES < ENTRY_SPAN) ? POOL_ENTRIES : ENTRY_SPAN;
	localparam int LW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          prev_we;
	logic [LW-1:0] prev_addr;
	logic [LW-1:0] prev_wdata;
	logic [LW-1:0] prev_rdata;
	logic          next_we;
	logic [LW-1:0] next_addr;
	logic [LW-1:0] next_wdata;
	logic [LW-1:0] next_rdata;
	logic          res_valid;
	logic          res_ready;
	res_t          res;
	logic          m_tvalid_q;
	logic [23:0]   m_tdata_q;

	ilru_link_ram #(
		.DEPTH (DEPTH),
		.AW    (LW)
	) u_prev_ram (
		.clk   (clk),
		.we    (prev_we),
		.addr  (prev_addr),
		.wdata (prev_wdata),
		.rdata (prev_rdata)
	);

	ilru_link_ram #(
		.DEPTH (DEPTH),
		.AW    (LW)
	) u_next_ram (
		.clk   (clk),
		.we    (next_we),
		.addr  (next_addr),
		.wdata (next_wdata),
		.rdata (next_rdata)
	);

	ilru_ctrl #(
		.POOL_ENTRIES (POOL_ENTRIES),
		.DEPTH        (DEPTH),
		.LW           (LW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_op      (s_tdata[2:0]),
		.in_entry   (s_tdata[12:3]),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res),
		.prev_we    (prev_we),
		.prev_addr  (prev_addr),
		.prev_wdata (prev_wdata),
		.prev_rdata (prev_rdata),
		.next_we    (next_we),
		.next_addr  (next_addr),
		.next_wdata (next_wdata),
		.next_rdata (next_rdata)
	);

	// The output register takes a new result whenever it is empty or being drained.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			m_tdata_q <= {2'b00, res.tail_index, res.head_index, res.list_empty, res.done_res};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
